// ===== sv/infix_expression_evaluator_defines.svh =====
// assertion macros for the infix expression evaluator
// no dependencies
`ifndef INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
// assert that a condition implies a consequence in the same cycle
`define IEE_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// assert that a condition implies a consequence in the next cycle
`define IEE_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/iee_pkg.sv =====
// shared types, codes and helpers for the infix expression evaluator
// no dependencies
package iee_pkg;
    localparam int StackDepth = 64;
    localparam int PtrW = $clog2(StackDepth);
    localparam int CntW = $clog2(StackDepth + 1);

    typedef logic [2:0] opcode_t;
    localparam opcode_t OP_ADD = 3'd0;
    localparam opcode_t OP_SUB = 3'd1;
    localparam opcode_t OP_MUL = 3'd2;
    localparam opcode_t OP_DIV = 3'd3;
    localparam opcode_t OP_LPAR = 3'd4;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK = 2'd0;
    localparam status_t ST_DIVZERO = 2'd1;
    localparam status_t ST_OVERFLOW = 2'd2;
    localparam status_t ST_MALFORMED = 2'd3;

    localparam logic [7:0] CH_PLUS = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_STAR = 8'h2a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_LPAR = 8'h28;
    localparam logic [7:0] CH_RPAR = 8'h29;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // controller to datapath commands
    typedef enum logic [2:0] {
        DC_NONE,
        DC_OPD_RD,   // read top two operands and top operator
        DC_ALU_GO,   // start arithmetic on latched operands
        DC_OPD_WR,   // write alu result onto new top
        DC_PUSH_NUM, // push number accumulator
        DC_OPR_RD    // read top operator only
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t cmd;
        opcode_t push_op;
        logic push_opr;
        logic pop_opr;
        logic digit;
        logic [3:0] digit_val;
        logic clear;
    } dp_ctrl_t;

    typedef struct packed {
        logic [CntW-1:0] opd_cnt;
        logic [CntW-1:0] opr_cnt;
        opcode_t top_op;
        logic alu_done;
        logic alu_divzero;
        logic [31:0] bottom;
    } dp_stat_t;

    function automatic logic [1:0] op_rank(input opcode_t op);
        logic [1:0] r;
        r = 2'd0;
        if (op == OP_ADD || op == OP_SUB) r = 2'd1;
        if (op == OP_MUL || op == OP_DIV) r = 2'd2;
        return r;
    endfunction
endpackage

// ===== sv/iee_stream_if.sv =====
// valid/ready stream interface for the evaluator channels
// depends on nothing but the payload width types given here
interface iee_in_if;
    logic valid;
    logic ready;
    logic [7:0] ch;
    logic last;
    modport source (output valid, ch, last, input ready);
    modport sink (input valid, ch, last, output ready);
endinterface

interface iee_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] value;
    logic [1:0] status;
    modport source (output valid, value, status, input ready);
    modport sink (input valid, value, status, output ready);
endinterface

// ===== sv/infix_expression_evaluator.sv =====
// Infix expression evaluator: takes one ASCII character per transfer on "in" and,
// after the transfer marked last, gives one transfer on "out" with the 32-bit
// value and a status (0 ok, 1 divide by zero, 2 stack overflow, 3 malformed).
// Digits build numbers, spaces are skipped, parentheses group, + - * / have
// the usual precedence; arithmetic wraps and division truncates toward zero.
// A plain character goes through S_IDLE and S_CHAR, with a second S_CHAR pass
// when it ends a number. Each operator reduction it triggers reads two operands
// and an operator, runs the alu and writes the result back; a division waits for
// the one-bit-per-cycle divider. The last character adds the final reductions,
// and the result waits while the previous one still waits for the receiver.
// Stacks are 64 entries deep, one in RAM each, no clearing pass.
// Depends on iee_pkg, the stream interfaces, the controller and the datapath.
`include "infix_expression_evaluator_defines.svh"
module infix_expression_evaluator
    import iee_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    iee_in_if.sink in_ch,
    iee_out_if.source out_ch
);
    dp_ctrl_t ctrl;
    dp_stat_t stat;

    // sequencing: decodes characters, drives stack and alu commands
    iee_controller u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .ctrl(ctrl), .stat(stat)
    );

    // stacks, accumulator and arithmetic units
    iee_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat)
    );

    // a push never happens on a full stack
    `IEE_ASSERT_IMPL(a_no_opd_ovf, clk, rst_n, ctrl.cmd == DC_PUSH_NUM,
        stat.opd_cnt < CntW'(StackDepth), "operand push on full stack")
    `IEE_ASSERT_IMPL(a_no_opr_ovf, clk, rst_n, ctrl.push_opr,
        stat.opr_cnt < CntW'(StackDepth), "operator push on full stack")
    // clearing returns both counts to empty
    `IEE_ASSERT_NEXT(a_clear, clk, rst_n, ctrl.clear,
        stat.opd_cnt == '0 && stat.opr_cnt == '0, "stacks not cleared")
endmodule

// ===== sv/iee_divider.sv =====
// iterative signed 32-bit divider, one quotient bit per cycle
// uses iee_pkg
module iee_divider
    import iee_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic busy,
    output logic done,
    output logic [31:0] q
);
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic [4:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic neg_reg, neg_next;
    logic [32:0] trial;

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next = neg_reg;
        trial = {rem_reg, quo_reg[31]} - {1'b0, den_reg};
        if (start)
        begin
            rem_next = '0;
            quo_next = a[31] ? 32'd0 - a : a;
            den_next = b[31] ? 32'd0 - b : b;
            neg_next = a[31] ^ b[31];
            cnt_next = 5'd31;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign q = neg_reg ? 32'd0 - quo_reg : quo_reg;
endmodule

// ===== sv/iee_datapath.sv =====
// stacks, number accumulator and arithmetic of the evaluator
// uses iee_pkg and iee_divider
module iee_datapath
    import iee_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  dp_ctrl_t ctrl,
    output dp_stat_t stat
);
    logic [31:0] opd_mem [StackDepth];
    opcode_t opr_mem [StackDepth];
    logic [CntW-1:0] opd_cnt_reg, opd_cnt_next;
    logic [CntW-1:0] opr_cnt_reg, opr_cnt_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] a_reg, b_reg, res_reg, bot_reg;
    opcode_t op_reg, top_reg;
    logic done_reg, dz_reg;
    logic div_start, div_busy, div_done;
    logic [31:0] div_q;
    logic [CntW-1:0] wr_cnt;
    logic [PtrW-1:0] a_addr;

    iee_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .a(a_reg), .b(b_reg),
        .busy(div_busy), .done(div_done), .q(div_q)
    );

    assign div_start = ctrl.cmd == DC_ALU_GO && op_reg == OP_DIV && b_reg != 32'd0;

    // second operand port: lower operand during a reduction, bottom entry otherwise
    assign a_addr = (ctrl.cmd == DC_OPD_RD) ? PtrW'(opd_cnt_reg - CntW'(2)) : '0;

    always_comb
    begin
        opd_cnt_next = opd_cnt_reg;
        opr_cnt_next = opr_cnt_reg;
        acc_next = acc_reg;
        wr_cnt = opd_cnt_reg - CntW'(1);
        if (ctrl.digit)
            acc_next = acc_reg * 32'd10 + {28'd0, ctrl.digit_val};
        if (ctrl.cmd == DC_PUSH_NUM)
        begin
            opd_cnt_next = opd_cnt_reg + CntW'(1);
            acc_next = '0;
        end
        if (ctrl.cmd == DC_OPD_RD)
            opd_cnt_next = opd_cnt_reg - CntW'(1);
        if (ctrl.push_opr)
            opr_cnt_next = opr_cnt_reg + CntW'(1);
        if (ctrl.pop_opr)
            opr_cnt_next = opr_cnt_reg - CntW'(1);
        if (ctrl.clear)
        begin
            opd_cnt_next = '0;
            opr_cnt_next = '0;
            acc_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opd_cnt_reg <= '0;
            opr_cnt_reg <= '0;
            acc_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            opd_cnt_reg <= opd_cnt_next;
            opr_cnt_reg <= opr_cnt_next;
            acc_reg <= acc_next;
            done_reg <= (ctrl.cmd == DC_ALU_GO && !div_start) || div_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cmd == DC_PUSH_NUM)
            opd_mem[opd_cnt_reg[PtrW-1:0]] <= acc_reg;
        if (ctrl.cmd == DC_OPD_WR)
            opd_mem[wr_cnt[PtrW-1:0]] <= res_reg;
        if (ctrl.push_opr)
            opr_mem[opr_cnt_reg[PtrW-1:0]] <= ctrl.push_op;
        if (ctrl.cmd == DC_OPD_RD)
        begin
            b_reg <= opd_mem[wr_cnt[PtrW-1:0]];
            a_reg <= opd_mem[a_addr];
        end
        else
            bot_reg <= opd_mem[a_addr];
        if (ctrl.cmd == DC_OPD_RD || ctrl.cmd == DC_OPR_RD)
            top_reg <= opr_mem[PtrW'(opr_cnt_reg - CntW'(1))];
        if (ctrl.cmd == DC_OPD_RD)
            op_reg <= opr_mem[PtrW'(opr_cnt_reg - CntW'(1))];
        if (ctrl.cmd == DC_ALU_GO)
        begin
            dz_reg <= op_reg == OP_DIV && b_reg == 32'd0;
            case (op_reg)
                OP_ADD: res_reg <= a_reg + b_reg;
                OP_SUB: res_reg <= a_reg - b_reg;
                OP_MUL: res_reg <= a_reg * b_reg;
                default: res_reg <= '0;
            endcase
        end
        else if (div_done)
            res_reg <= div_q;
    end

    assign stat.opd_cnt = opd_cnt_reg;
    assign stat.opr_cnt = opr_cnt_reg;
    assign stat.top_op = top_reg;
    assign stat.alu_done = done_reg && !div_busy;
    assign stat.alu_divzero = dz_reg;
    assign stat.bottom = bot_reg;
endmodule

// ===== sv/iee_controller.sv =====
// sequencing state machine of the evaluator
// uses iee_pkg
module iee_controller
    import iee_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    iee_in_if.sink in_ch,
    iee_out_if.source out_ch,
    output dp_ctrl_t ctrl,
    input  dp_stat_t stat
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHAR, S_PEEK, S_PEEK_W, S_RED_RD, S_RED_GO, S_RED_WAIT,
        S_RED_WR, S_FIN, S_OUT
    } state_t;

    // what the reduction loop is working for
    typedef enum logic [1:0] {
        G_RPAR, G_OPER, G_FIN
    } goal_t;

    state_t state_reg, state_next;
    goal_t goal_reg, goal_next;
    logic [7:0] ch_reg, ch_next;
    logic last_reg, last_next;
    opcode_t code_reg, code_next;
    status_t err_reg, err_next;
    logic in_num_reg, in_num_next;
    logic want_reg, want_next;
    logic fin_pushed_reg, fin_pushed_next;
    logic ovalid_reg, ovalid_next;
    logic [31:0] oval_reg, oval_next;
    status_t ost_reg, ost_next;
    logic fatal;
    logic is_digit;

    assign fatal = err_reg == ST_OVERFLOW || err_reg == ST_MALFORMED;
    assign is_digit = ch_reg >= CH_ZERO && ch_reg <= CH_NINE;

    function automatic status_t raise(input status_t cur, input status_t code);
        status_t r;
        r = cur;
        if (code == ST_DIVZERO)
        begin
            if (cur == ST_OK) r = ST_DIVZERO;
        end
        else if (cur == ST_OK || cur == ST_DIVZERO)
            r = code;
        return r;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        goal_next = goal_reg;
        ch_next = ch_reg;
        last_next = last_reg;
        code_next = code_reg;
        err_next = err_reg;
        in_num_next = in_num_reg;
        want_next = want_reg;
        fin_pushed_next = fin_pushed_reg;
        ovalid_next = ovalid_reg;
        oval_next = oval_reg;
        ost_next = ost_reg;
        ctrl = '0;
        ctrl.cmd = DC_NONE;
        in_ch.ready = 1'b0;
        if (out_ch.ready)
            ovalid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    ch_next = in_ch.ch;
                    last_next = in_ch.last;
                    state_next = S_CHAR;
                end
            end
            S_CHAR:
            begin
                state_next = last_reg ? S_FIN : S_IDLE;
                fin_pushed_next = 1'b0;
                if (fatal)
                begin
                end
                else if (is_digit)
                begin
                    if (!in_num_reg && !want_reg)
                        err_next = raise(err_reg, ST_MALFORMED);
                    else
                    begin
                        in_num_next = 1'b1;
                        ctrl.digit = 1'b1;
                        ctrl.digit_val = ch_reg[3:0];
                    end
                end
                else if (in_num_reg)
                begin
                    // flush the number, then come back for this character
                    in_num_next = 1'b0;
                    want_next = 1'b0;
                    state_next = S_CHAR;
                    if (stat.opd_cnt >= CntW'(StackDepth))
                        err_next = raise(err_reg, ST_OVERFLOW);
                    else
                        ctrl.cmd = DC_PUSH_NUM;
                end
                else if (ch_reg == CH_SPACE)
                begin
                end
                else if (ch_reg == CH_LPAR)
                begin
                    if (!want_reg)
                        err_next = raise(err_reg, ST_MALFORMED);
                    else if (stat.opr_cnt >= CntW'(StackDepth))
                        err_next = raise(err_reg, ST_OVERFLOW);
                    else
                    begin
                        ctrl.push_opr = 1'b1;
                        ctrl.push_op = OP_LPAR;
                    end
                end
                else if (ch_reg == CH_RPAR)
                begin
                    if (want_reg)
                        err_next = raise(err_reg, ST_MALFORMED);
                    else
                    begin
                        goal_next = G_RPAR;
                        state_next = S_PEEK;
                    end
                end
                else if (ch_reg == CH_PLUS || ch_reg == CH_MINUS ||
                         ch_reg == CH_STAR || ch_reg == CH_SLASH)
                begin
                    if (ch_reg == CH_PLUS) code_next = OP_ADD;
                    else if (ch_reg == CH_MINUS) code_next = OP_SUB;
                    else if (ch_reg == CH_STAR) code_next = OP_MUL;
                    else code_next = OP_DIV;
                    if (want_reg)
                        err_next = raise(err_reg, ST_MALFORMED);
                    else
                    begin
                        goal_next = G_OPER;
                        state_next = S_PEEK;
                    end
                end
                else
                    err_next = raise(err_reg, ST_MALFORMED);
            end
            S_PEEK:
            begin
                ctrl.cmd = DC_OPR_RD;
                state_next = S_PEEK_W;
            end
            S_PEEK_W:
            begin
                state_next = last_reg ? S_FIN : S_IDLE;
                case (goal_reg)
                    G_RPAR:
                    begin
                        if (stat.opr_cnt == '0)
                            err_next = raise(err_reg, ST_MALFORMED);
                        else if (stat.top_op == OP_LPAR)
                            ctrl.pop_opr = 1'b1;
                        else
                            state_next = S_RED_RD;
                    end
                    G_OPER:
                    begin
                        if (stat.opr_cnt != '0 &&
                            op_rank(stat.top_op) >= op_rank(code_reg))
                            state_next = S_RED_RD;
                        else if (stat.opr_cnt >= CntW'(StackDepth))
                            err_next = raise(err_reg, ST_OVERFLOW);
                        else
                        begin
                            ctrl.push_opr = 1'b1;
                            ctrl.push_op = code_reg;
                            want_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (stat.opr_cnt == '0)
                        begin
                            if (stat.opd_cnt != CntW'(1))
                                err_next = raise(err_reg, ST_MALFORMED);
                            state_next = S_OUT;
                        end
                        else if (stat.top_op == OP_LPAR)
                        begin
                            err_next = raise(err_reg, ST_MALFORMED);
                            state_next = S_OUT;
                        end
                        else
                            state_next = S_RED_RD;
                    end
                endcase
            end
            S_RED_RD:
            begin
                if (stat.opd_cnt < CntW'(2))
                begin
                    err_next = raise(err_reg, ST_MALFORMED);
                    state_next = (goal_reg == G_FIN) ? S_OUT
                               : (last_reg ? S_FIN : S_IDLE);
                end
                else
                begin
                    ctrl.cmd = DC_OPD_RD;
                    ctrl.pop_opr = 1'b1;
                    state_next = S_RED_GO;
                end
            end
            S_RED_GO:
            begin
                ctrl.cmd = DC_ALU_GO;
                state_next = S_RED_WAIT;
            end
            S_RED_WAIT:
            begin
                if (stat.alu_done)
                    state_next = S_RED_WR;
            end
            S_RED_WR:
            begin
                ctrl.cmd = DC_OPD_WR;
                if (stat.alu_divzero)
                    err_next = raise(err_reg, ST_DIVZERO);
                state_next = S_PEEK;
            end
            S_FIN:
            begin
                if (fatal)
                    state_next = S_OUT;
                else if (in_num_reg)
                begin
                    in_num_next = 1'b0;
                    want_next = 1'b0;
                    if (stat.opd_cnt >= CntW'(StackDepth))
                    begin
                        err_next = raise(err_reg, ST_OVERFLOW);
                        state_next = S_OUT;
                    end
                    else
                        ctrl.cmd = DC_PUSH_NUM;
                end
                else if (want_reg)
                begin
                    err_next = raise(err_reg, ST_MALFORMED);
                    state_next = S_OUT;
                end
                else
                begin
                    goal_next = G_FIN;
                    state_next = S_PEEK;
                end
            end
            S_OUT:
            begin
                // wait for the registered bottom read, and for the output slot
                if (!ovalid_reg || out_ch.ready)
                begin
                    if (fin_pushed_reg)
                    begin
                        ovalid_next = 1'b1;
                        oval_next = fatal ? 32'd0 : stat.bottom;
                        ost_next = err_reg;
                        ctrl.clear = 1'b1;
                        err_next = ST_OK;
                        in_num_next = 1'b0;
                        want_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    fin_pushed_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            goal_reg <= G_FIN;
            err_reg <= ST_OK;
            in_num_reg <= 1'b0;
            want_reg <= 1'b1;
            fin_pushed_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            goal_reg <= goal_next;
            err_reg <= err_next;
            in_num_reg <= in_num_next;
            want_reg <= want_next;
            fin_pushed_reg <= fin_pushed_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg <= ch_next;
        last_reg <= last_next;
        code_reg <= code_next;
        oval_reg <= oval_next;
        ost_reg <= ost_next;
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.value = oval_reg;
    assign out_ch.status = ost_reg;
endmodule
